// ===== rtl/core/isl_pkg.sv =====
// Shared constants, command codes and cell control types for the indexed shift list.
package isl_pkg;

    // Built depth of the cell row and width of one entry.
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 64;

    // Count, position and capacity fields are seven bits wide.
    localparam int CNT_W = 7;
    localparam int CMD_W = 4;

    // The read path ORs the row in groups before the final merge.
    localparam int GRP_SIZE = 8;
    localparam int NUM_GRP  = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    // Capacity register value after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // Command codes carried on the command port.
    localparam logic [CMD_W-1:0] CMD_GET       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SET       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ADD_FIRST = 4'd3;
    localparam logic [CMD_W-1:0] CMD_ADD_LAST  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_REM_FIRST = 4'd5;
    localparam logic [CMD_W-1:0] CMD_REM_LAST  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_REM_IDX   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REM_VALUE = 4'd8;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd9;

    // Per-cycle operation broadcast to every cell.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_OPEN,
        CELL_CLOSE
    } t_cell_op;

    // Control bundle shared by the whole row.
    typedef struct packed {
        t_cell_op             op;
        logic [CNT_W-1:0]     at;
        logic [CNT_W-1:0]     count;
        logic [WORD_BITS-1:0] data;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/isl_cell.sv =====
// One storage cell of the list row: holds an entry and shifts with its neighbors.
module isl_cell (
    input  logic                           i_clk,
    input  logic [isl_pkg::CNT_W-1:0]      i_index,
    input  isl_pkg::t_cell_ctrl            i_ctrl,
    input  logic [isl_pkg::WORD_BITS-1:0]  i_left_word,
    input  logic [isl_pkg::WORD_BITS-1:0]  i_right_word,
    output logic [isl_pkg::WORD_BITS-1:0]  o_word,
    output logic                           o_match
);

    logic [isl_pkg::WORD_BITS-1:0] r_word;
    logic [isl_pkg::WORD_BITS-1:0] n_word;
    logic                          w_live;
    logic                          w_close_take;

    // This cell lies below the fill count, so it holds a written entry.
    assign w_live = (i_index < i_ctrl.count);

    // On a close, this cell takes its upper neighbor if that neighbor is live.
    assign w_close_take = (i_index >= i_ctrl.at) &&
                          (({1'b0, i_index} + 8'd1) < {1'b0, i_ctrl.count});

    // Next entry value from the broadcast operation.
    always_comb begin
        n_word = r_word;
        case (i_ctrl.op)
            isl_pkg::CELL_HOLD: begin
                n_word = r_word;
            end
            isl_pkg::CELL_WRITE: begin
                if (i_index == i_ctrl.at) begin
                    n_word = i_ctrl.data;
                end
            end
            isl_pkg::CELL_OPEN: begin
                if (i_index == i_ctrl.at) begin
                    n_word = i_ctrl.data;
                end else if ((i_index > i_ctrl.at) && (i_index <= i_ctrl.count)) begin
                    n_word = i_left_word;
                end
            end
            isl_pkg::CELL_CLOSE: begin
                if (w_close_take) begin
                    n_word = i_right_word;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // Entry storage; it has no reset and is only read once written.
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // Value compare for removal by value, qualified by occupancy.
    assign o_match = w_live && (r_word == i_ctrl.data);
    assign o_word  = r_word;

endmodule

// ===== rtl/core/indexed_shift_list_core.sv =====
// Top level of the indexed shift list: command sequencer driving a row of shift cells.
//
//  channel   | direction | handshake                     | beat contents
//  ----------+-----------+-------------------------------+------------------------------------
//  command   | in        | start high while busy is low  | i_cmd, i_position, i_data_word
//  result    | out       | o_result_valid, one cycle     | o_ok, o_read_word, o_count
//  config    | in        | i_cfg_valid and o_cfg_ready   | i_cfg_data (capacity limit)
//
// Each command passes from the accepting edge to the result strobe in these steps: capture
// it, the row-wide compare and target select, the cell shift and grouped read, and the
// merge of the read into the registered result.
// busy stays high from acceptance until the result beat is shown; a new command can be
// accepted in the same cycle as that beat. The receiver cannot stall the result.
// Reset clears the fill count, sets the capacity limit to 64 and leaves entries unwritten;
// no clearing pass is needed. The config channel is always ready.
module indexed_shift_list_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [isl_pkg::CMD_W-1:0]           i_cmd,
    input  logic [isl_pkg::CNT_W-1:0]           i_position,
    input  logic [isl_pkg::WORD_BITS-1:0]       i_data_word,
    // result channel
    output logic                                o_result_valid,
    output logic                                o_ok,
    output logic [isl_pkg::WORD_BITS-1:0]       o_read_word,
    output logic [isl_pkg::CNT_W-1:0]           o_count,
    // config channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [isl_pkg::CNT_W-1:0]           i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY,
        S_DONE
    } t_state;

    t_state                              r_state;
    logic [isl_pkg::CNT_W-1:0]           r_count;
    logic [isl_pkg::CNT_W-1:0]           r_cap;
    logic [isl_pkg::CMD_W-1:0]           r_cmd;
    logic [isl_pkg::CNT_W-1:0]           r_position;
    logic [isl_pkg::WORD_BITS-1:0]       r_data;
    logic [isl_pkg::CNT_W-1:0]           r_at;
    logic                                r_ok;
    logic                                r_rd;
    isl_pkg::t_cell_op                   r_op;
    logic [isl_pkg::CNT_W-1:0]           r_new_count;
    logic [isl_pkg::WORD_BITS-1:0]       r_grp [isl_pkg::NUM_GRP];
    logic                                r_result_valid;
    logic                                r_res_ok;
    logic [isl_pkg::WORD_BITS-1:0]       r_res_word;
    logic [isl_pkg::CNT_W-1:0]           r_res_count;

    logic [isl_pkg::CNT_W-1:0]           n_at;
    logic                                n_ok;
    logic                                n_rd;
    isl_pkg::t_cell_op                   n_op;
    logic [isl_pkg::CNT_W-1:0]           n_new_count;
    logic [isl_pkg::WORD_BITS-1:0]       n_grp [isl_pkg::NUM_GRP];
    logic [isl_pkg::WORD_BITS-1:0]       n_read_word;

    isl_pkg::t_cell_ctrl                 w_ctrl;
    logic [isl_pkg::WORD_BITS-1:0]       w_word [isl_pkg::DEPTH];
    logic [isl_pkg::DEPTH-1:0]           w_hit;
    logic [isl_pkg::DEPTH-1:0]           w_first;
    logic [isl_pkg::CNT_W-1:0]           w_first_idx;
    logic [isl_pkg::CNT_W-1:0]           w_eff_cap;
    logic                                w_room;
    logic                                w_accept;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Capacity in effect is the smaller of the register and the built depth.
    assign w_eff_cap = (r_cap < isl_pkg::CNT_W'(isl_pkg::DEPTH)) ?
                       r_cap : isl_pkg::CNT_W'(isl_pkg::DEPTH);
    assign w_room    = (r_count < w_eff_cap);

    // Broadcast control; cells only change state during the apply cycle.
    always_comb begin
        w_ctrl.op    = (r_state == S_APPLY) ? r_op : isl_pkg::CELL_HOLD;
        w_ctrl.at    = r_at;
        w_ctrl.count = r_count;
        w_ctrl.data  = r_data;
    end

    // Row of cells, each linked to its lower and upper neighbor.
    for (genvar gi = 0; gi < isl_pkg::DEPTH; gi++) begin : g_cell
        logic [isl_pkg::WORD_BITS-1:0] w_left;
        logic [isl_pkg::WORD_BITS-1:0] w_right;

        if (gi == 0) begin : g_lo
            assign w_left = '0;
        end else begin : g_lo
            assign w_left = w_word[gi-1];
        end

        if (gi == isl_pkg::DEPTH - 1) begin : g_hi
            assign w_right = '0;
        end else begin : g_hi
            assign w_right = w_word[gi+1];
        end

        isl_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (isl_pkg::CNT_W'(gi)),
            .i_ctrl       (w_ctrl),
            .i_left_word  (w_left),
            .i_right_word (w_right),
            .o_word       (w_word[gi]),
            .o_match      (w_hit[gi])
        );
    end

    // Lowest matching cell as a one-hot vector, then as an index.
    assign w_first = w_hit & (~w_hit + 1'b1);

    always_comb begin
        w_first_idx = '0;
        for (int i = 0; i < isl_pkg::DEPTH; i++) begin
            w_first_idx = w_first_idx | ({isl_pkg::CNT_W{w_first[i]}} & isl_pkg::CNT_W'(i));
        end
    end

    // Command decode: success, target index, cell operation and new count.
    always_comb begin
        n_ok        = 1'b0;
        n_rd        = 1'b0;
        n_at        = r_position;
        n_op        = isl_pkg::CELL_HOLD;
        n_new_count = r_count;
        case (r_cmd)
            isl_pkg::CMD_GET: begin
                n_ok = (r_position < r_count);
                n_rd = n_ok;
            end
            isl_pkg::CMD_SET: begin
                n_ok = (r_position < r_count);
                n_op = n_ok ? isl_pkg::CELL_WRITE : isl_pkg::CELL_HOLD;
            end
            isl_pkg::CMD_INSERT, isl_pkg::CMD_ADD_FIRST, isl_pkg::CMD_ADD_LAST: begin
                if (r_cmd == isl_pkg::CMD_ADD_FIRST) begin
                    n_at = '0;
                end else if (r_cmd == isl_pkg::CMD_ADD_LAST) begin
                    n_at = r_count;
                end
                n_ok = w_room && (n_at <= r_count);
                if (n_ok) begin
                    n_op        = isl_pkg::CELL_OPEN;
                    n_new_count = r_count + 1'b1;
                end
            end
            isl_pkg::CMD_REM_FIRST, isl_pkg::CMD_REM_LAST, isl_pkg::CMD_REM_IDX: begin
                if (r_cmd == isl_pkg::CMD_REM_FIRST) begin
                    n_at = '0;
                end else if (r_cmd == isl_pkg::CMD_REM_LAST) begin
                    n_at = r_count - 1'b1;
                end
                n_ok = (r_count != '0) && (n_at < r_count);
                n_rd = n_ok;
                if (n_ok) begin
                    n_op        = isl_pkg::CELL_CLOSE;
                    n_new_count = r_count - 1'b1;
                end
            end
            isl_pkg::CMD_REM_VALUE: begin
                n_at = w_first_idx;
                n_ok = |w_hit;
                n_rd = n_ok;
                if (n_ok) begin
                    n_op        = isl_pkg::CELL_CLOSE;
                    n_new_count = r_count - 1'b1;
                end
            end
            isl_pkg::CMD_CLEAR: begin
                n_ok        = 1'b1;
                n_new_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Grouped read of the target cell, taken before the row shifts.
    always_comb begin
        for (int g = 0; g < isl_pkg::NUM_GRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < isl_pkg::GRP_SIZE; k++) begin
                if ((g * isl_pkg::GRP_SIZE + k) < isl_pkg::DEPTH) begin
                    if (r_at == isl_pkg::CNT_W'(g * isl_pkg::GRP_SIZE + k)) begin
                        n_grp[g] = n_grp[g] | w_word[g * isl_pkg::GRP_SIZE + k];
                    end
                end
            end
        end
    end

    // Final merge of the group results.
    always_comb begin
        n_read_word = '0;
        for (int g = 0; g < isl_pkg::NUM_GRP; g++) begin
            n_read_word = n_read_word | r_grp[g];
        end
    end

    // Sequencer, fill count, capacity register and result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_cap          <= isl_pkg::CAP_RESET;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd      <= i_cmd;
                        r_position <= i_position;
                        r_data     <= i_data_word;
                        r_state    <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_at        <= n_at;
                    r_ok        <= n_ok;
                    r_rd        <= n_rd;
                    r_op        <= n_op;
                    r_new_count <= n_new_count;
                    r_state     <= S_APPLY;
                end
                S_APPLY: begin
                    r_grp   <= n_grp;
                    r_count <= r_new_count;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_result_valid <= 1'b1;
                    r_res_ok       <= r_ok;
                    r_res_word     <= r_rd ? n_read_word : '0;
                    r_res_count    <= r_count;
                    r_state        <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_ok           = r_res_ok;
    assign o_read_word    = r_res_word;
    assign o_count        = r_res_count;

endmodule

// ===== rtl/core/isl_checker.sv =====
// Port-level checks for the indexed shift list top level, with the bind that attaches them.
module isl_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_result_valid,
    input logic                                o_ok,
    input logic [isl_pkg::WORD_BITS-1:0]       o_read_word,
    input logic [isl_pkg::CNT_W-1:0]           o_count
);

    // Every accepted command yields its result beat.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_result_valid)
        else $error("result beat missing four cycles after command acceptance");

    // One command yields exactly one beat.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result beat repeated");

    // A failed command returns a zero data word.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_ok) |-> (o_read_word == '0))
        else $error("failed command returned nonzero data");

    // The count never exceeds the built depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_count <= isl_pkg::CNT_W'(isl_pkg::DEPTH)))
        else $error("count beyond the built depth");

endmodule

bind indexed_shift_list_core isl_checker u_isl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_ok           (o_ok),
    .o_read_word    (o_read_word),
    .o_count        (o_count)
);
